>>> design/ethl4_pkg.sv
package ethl4_pkg;

	// Byte counter width (11 to 16) and its saturation value
	localparam int COUNT_BITS = 16;
	typedef logic [COUNT_BITS-1:0] count_t;
	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	// Output field widths fixed by the result format
	localparam int STATUS_W = 3;
	localparam int PORT_W   = 16;
	localparam int ADDR_W   = 32;
	localparam int OFFS_W   = 16;

	// Header geometry
	localparam int ETH_HDR_LEN = 14;
	localparam int TCP_MIN_LEN = 20;
	localparam int UDP_HDR_LEN = 8;
	localparam int HDR_END_W   = 7;   // 14 + 4 * 15 fits in 7 bits
	localparam int XPORT_END_W = 8;   // header end plus up to 60 TCP bytes

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// Fixed byte positions within the frame
	localparam count_t POS_TYPE_HI   = count_t'(12);
	localparam count_t POS_TYPE_LO   = count_t'(13);
	localparam count_t POS_IHL       = count_t'(14);
	localparam count_t POS_PROTO     = count_t'(23);
	localparam count_t POS_SRC_FIRST = count_t'(26);
	localparam count_t POS_SRC_LAST  = count_t'(29);
	localparam count_t POS_DST_FIRST = count_t'(30);
	localparam count_t POS_DST_LAST  = count_t'(33);

	// Positions relative to the transport header start
	localparam count_t REL_SPORT_LAST = count_t'(1);
	localparam count_t REL_DPORT_LAST = count_t'(3);
	localparam count_t REL_TCP_OFFS   = count_t'(12);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_SHORT_ETH = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_TRUNC_IP  = 3'd3,
		ST_TRUNC_TCP = 3'd4,
		ST_BAD_TCP   = 3'd5,
		ST_TRUNC_UDP = 3'd6
	} status_t;

	// Header fields of the current frame, including the word in flight
	typedef struct packed {
		count_t              frame_len;
		logic [15:0]         ether_kind;
		logic [3:0]          ip_words;
		logic [7:0]          proto;
		logic [ADDR_W-1:0]   src_addr;
		logic [ADDR_W-1:0]   dst_addr;
		logic [PORT_W-1:0]   sport;
		logic [PORT_W-1:0]   dport;
		logic [3:0]          tcp_words;
	} hdr_fields_t;

endpackage

>>> design/ethl4_capture.sv
module ethl4_capture (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [7:0]             frame_byte,
	input  logic                   frame_end,
	input  logic                   advance,
	output logic                   s1_valid,
	output logic                   s1_end,
	output ethl4_pkg::hdr_fields_t fields
);

	logic                 valid_s1;
	logic                 end_s1;
	logic [7:0]           byte_s1;

	ethl4_pkg::count_t    count_q;
	logic [15:0]          ether_q;
	logic [3:0]           ipw_q;
	logic [7:0]           proto_q;
	logic [31:0]          src_q;
	logic [31:0]          dst_q;
	logic [15:0]          sport_q;
	logic [15:0]          dport_q;
	logic [3:0]           tcpw_q;

	ethl4_pkg::count_t    pos;
	logic [3:0]           ipw_n;
	logic [ethl4_pkg::HDR_END_W-1:0] base;
	ethl4_pkg::count_t    base_ext;
	ethl4_pkg::count_t    rel;
	ethl4_pkg::hdr_fields_t nxt;

	// Hold the incoming word until the header logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	// Decode the word against its position in the frame
	assign pos      = count_q;
	assign ipw_n    = (pos == ethl4_pkg::POS_IHL) ? byte_s1[3:0] : ipw_q;
	assign base     = ethl4_pkg::HDR_END_W'(ethl4_pkg::ETH_HDR_LEN) + {1'b0, ipw_n, 2'b00};
	assign base_ext = ethl4_pkg::count_t'(base);
	assign rel      = pos - base_ext;

	always_comb begin
		nxt.frame_len  = (pos != ethl4_pkg::COUNT_MAX) ? pos + 1'b1 : pos;
		nxt.ether_kind = ether_q;
		nxt.ip_words   = ipw_n;
		nxt.proto      = proto_q;
		nxt.src_addr   = src_q;
		nxt.dst_addr   = dst_q;
		nxt.sport      = sport_q;
		nxt.dport      = dport_q;
		nxt.tcp_words  = tcpw_q;

		if (pos == ethl4_pkg::POS_TYPE_HI) begin
			nxt.ether_kind = {byte_s1, 8'h00};
		end
		if (pos == ethl4_pkg::POS_TYPE_LO) begin
			nxt.ether_kind = ether_q | {8'h00, byte_s1};
		end
		if (pos == ethl4_pkg::POS_PROTO) begin
			nxt.proto = byte_s1;
		end
		if (pos >= ethl4_pkg::POS_SRC_FIRST && pos <= ethl4_pkg::POS_SRC_LAST) begin
			nxt.src_addr = {src_q[23:0], byte_s1};
		end
		if (pos >= ethl4_pkg::POS_DST_FIRST && pos <= ethl4_pkg::POS_DST_LAST) begin
			nxt.dst_addr = {dst_q[23:0], byte_s1};
		end

		// Transport header fields, relative to the end of the IP header
		if (pos >= base_ext) begin
			priority if (rel <= ethl4_pkg::REL_SPORT_LAST) begin
				nxt.sport = {sport_q[7:0], byte_s1};
			end else if (rel <= ethl4_pkg::REL_DPORT_LAST) begin
				nxt.dport = {dport_q[7:0], byte_s1};
			end else if (rel == ethl4_pkg::REL_TCP_OFFS) begin
				nxt.tcp_words = byte_s1[7:4];
			end else begin
				nxt.tcp_words = tcpw_q;
			end
		end
	end

	// Advance the frame state; clear it after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ether_q <= '0;
			ipw_q   <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
			tcpw_q  <= '0;
		end else if (advance) begin
			if (end_s1) begin
				count_q <= '0;
				ether_q <= '0;
				ipw_q   <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
				tcpw_q  <= '0;
			end else begin
				count_q <= nxt.frame_len;
				ether_q <= nxt.ether_kind;
				ipw_q   <= nxt.ip_words;
				proto_q <= nxt.proto;
				src_q   <= nxt.src_addr;
				dst_q   <= nxt.dst_addr;
				sport_q <= nxt.sport;
				dport_q <= nxt.dport;
				tcpw_q  <= nxt.tcp_words;
			end
		end
	end

	assign s1_valid = valid_s1;
	assign s1_end   = end_s1;
	assign fields   = nxt;

endmodule

>>> design/ethl4_verdict.sv
module ethl4_verdict (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   result_load,
	input  ethl4_pkg::hdr_fields_t fields,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [2:0]             parse_status,
	output logic [7:0]             ip_protocol,
	output logic [31:0]            source_address,
	output logic [31:0]            dest_address,
	output logic [15:0]            source_port,
	output logic [15:0]            dest_port,
	output logic [15:0]            payload_offset,
	output logic [15:0]            payload_length
);

	localparam int HW = ethl4_pkg::HDR_END_W;
	localparam int XW = ethl4_pkg::XPORT_END_W;

	logic [5:0]                ip_len;
	logic [5:0]                tcp_len;
	logic [HW-1:0]             hdr_end;
	ethl4_pkg::count_t         len;
	ethl4_pkg::count_t         tlen;
	ethl4_pkg::count_t         tcp_len_ext;

	ethl4_pkg::status_t        st;
	logic [7:0]                proto;
	logic [31:0]               sa;
	logic [31:0]               da;
	logic [15:0]               sp;
	logic [15:0]               dp;
	logic [XW-1:0]             poff;
	ethl4_pkg::count_t         plen;

	logic                      valid_q;
	ethl4_pkg::status_t        status_q;
	logic [7:0]                proto_q;
	logic [31:0]               sa_q;
	logic [31:0]               da_q;
	logic [15:0]               sp_q;
	logic [15:0]               dp_q;
	logic [15:0]               poff_q;
	logic [15:0]               plen_q;

	// Header lengths in bytes
	assign len         = fields.frame_len;
	assign ip_len      = {fields.ip_words, 2'b00};
	assign tcp_len     = {fields.tcp_words, 2'b00};
	assign tcp_len_ext = ethl4_pkg::count_t'(tcp_len);
	assign hdr_end     = HW'(ethl4_pkg::ETH_HDR_LEN) + {1'b0, ip_len};
	assign tlen        = len - ethl4_pkg::count_t'(hdr_end);

	// Run the checks in order and select the summary fields
	always_comb begin
		st    = ethl4_pkg::ST_OK;
		proto = '0;
		sa    = '0;
		da    = '0;
		sp    = '0;
		dp    = '0;
		poff  = '0;
		plen  = '0;
		priority if (len < ethl4_pkg::count_t'(ethl4_pkg::ETH_HDR_LEN)) begin
			st = ethl4_pkg::ST_SHORT_ETH;
		end else if (fields.ether_kind != ethl4_pkg::ETHERTYPE_IPV4) begin
			st = ethl4_pkg::ST_NOT_IPV4;
		end else if (len <= ethl4_pkg::count_t'(ethl4_pkg::ETH_HDR_LEN)
				|| ethl4_pkg::count_t'(hdr_end) > len) begin
			st = ethl4_pkg::ST_TRUNC_IP;
		end else begin
			proto = fields.proto;
			sa    = fields.src_addr;
			da    = fields.dst_addr;
			priority if (fields.proto == ethl4_pkg::PROTO_TCP) begin
				priority if (tlen < ethl4_pkg::count_t'(ethl4_pkg::TCP_MIN_LEN)) begin
					st = ethl4_pkg::ST_TRUNC_TCP;
				end else begin
					sp = fields.sport;
					dp = fields.dport;
					if (tcp_len < 6'(ethl4_pkg::TCP_MIN_LEN) || tcp_len_ext > tlen) begin
						st = ethl4_pkg::ST_BAD_TCP;
					end else begin
						poff = XW'(hdr_end) + XW'(tcp_len);
						plen = tlen - tcp_len_ext;
					end
				end
			end else if (fields.proto == ethl4_pkg::PROTO_UDP) begin
				if (tlen < ethl4_pkg::count_t'(ethl4_pkg::UDP_HDR_LEN)) begin
					st = ethl4_pkg::ST_TRUNC_UDP;
				end else begin
					sp   = fields.sport;
					dp   = fields.dport;
					poff = XW'(hdr_end) + XW'(ethl4_pkg::UDP_HDR_LEN);
					plen = tlen - ethl4_pkg::count_t'(ethl4_pkg::UDP_HDR_LEN);
				end
			end else begin
				poff = XW'(hdr_end);
				plen = tlen;
			end
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (result_load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			status_q <= st;
			proto_q  <= proto;
			sa_q     <= sa;
			da_q     <= da;
			sp_q     <= sp;
			dp_q     <= dp;
			poff_q   <= 16'(poff);
			plen_q   <= 16'(plen);
		end
	end

	assign out_valid      = valid_q;
	assign parse_status   = status_q;
	assign ip_protocol    = proto_q;
	assign source_address = sa_q;
	assign dest_address   = da_q;
	assign source_port    = sp_q;
	assign dest_port      = dp_q;
	assign payload_offset = poff_q;
	assign payload_length = plen_q;

endmodule

>>> design/eth_ipv4_l4_header_parser.sv
// A last byte is held in the capture register; its frame's result then goes to the output register.
// Throughput: one frame byte per cycle; a frame's result leaves through a one-word output register.
// Bytes keep flowing while a result waits; only a second last byte stalls behind a held result.
// Reset (arst_n low, asynchronous): drops any held byte and result and clears all frame state.
module eth_ipv4_l4_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  parse_status,
	output logic [7:0]  ip_protocol,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length
);

	logic                   s1_valid;
	logic                   s1_end;
	logic                   out_free;
	logic                   advance;
	logic                   load;
	ethl4_pkg::hdr_fields_t fields;

	// Advance the held byte unless it closes a frame and the result slot is full
	assign out_free = !out_valid || !out_stall;
	assign advance  = s1_valid && (!s1_end || out_free);
	assign in_stall = s1_valid && !advance;
	assign load     = in_valid && !in_stall;

	ethl4_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.advance    (advance),
		.s1_valid   (s1_valid),
		.s1_end     (s1_end),
		.fields     (fields)
	);

	ethl4_verdict u_verdict (
		.clk            (clk),
		.arst_n         (arst_n),
		.result_load    (advance && s1_end),
		.fields         (fields),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.parse_status   (parse_status),
		.ip_protocol    (ip_protocol),
		.source_address (source_address),
		.dest_address   (dest_address),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.payload_offset (payload_offset),
		.payload_length (payload_length)
	);

endmodule

>>> design/ethl4_checker.sv
module ethl4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  parse_status,
	input logic [7:0]  ip_protocol,
	input logic [31:0] source_address,
	input logic [31:0] dest_address,
	input logic [15:0] source_port,
	input logic [15:0] payload_offset,
	input logic [15:0] payload_length
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parse_status)
			&& $stable(payload_length))
		else $error("result word changed while stalled");

	// Any error leaves no payload
	a_err_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status != ethl4_pkg::ST_OK
			|-> payload_offset == 16'd0 && payload_length == 16'd0)
		else $error("payload reported on an errored frame");

	// Frames that fail before the IP header give no IP fields
	a_early_err_no_ip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (parse_status == ethl4_pkg::ST_SHORT_ETH
			|| parse_status == ethl4_pkg::ST_NOT_IPV4
			|| parse_status == ethl4_pkg::ST_TRUNC_IP)
			|-> ip_protocol == 8'd0 && source_address == 32'd0 && dest_address == 32'd0)
		else $error("IP fields reported on an early error");

	// A truncated TCP header comes only from TCP and gives no source port
	a_trunc_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_status == ethl4_pkg::ST_TRUNC_TCP
			|-> ip_protocol == ethl4_pkg::PROTO_TCP && source_port == 16'd0)
		else $error("inconsistent truncated TCP result");

endmodule

bind eth_ipv4_l4_header_parser ethl4_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.parse_status   (parse_status),
	.ip_protocol    (ip_protocol),
	.source_address (source_address),
	.dest_address   (dest_address),
	.source_port    (source_port),
	.payload_offset (payload_offset),
	.payload_length (payload_length)
);
